### design/rrba_pkg.sv
// Shared types and constants for the round-robin block allocator.
// Holds request kinds, result status codes, the queue entry layout and reset values.
// No dependencies.
package rrba_pkg;

  // Field widths of the request and result channels
  localparam int ID_W    = 10;
  localparam int BLOCK_W = 16;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;

  // Defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int SHARE_DIVISOR_DEF = 10;

  // Pool and refill budget value after reset
  localparam logic [BLOCK_W-1:0] BUDGET_RESET = 16'd1000;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REFILL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SERVE   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_ENQUEUED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REFILLED  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_GRANTED   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd5;

  // One pending request as stored in the queue memory
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BLOCK_W-1:0] count;
  } rrba_entry_t;

endpackage

### design/rrba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; width and depth come in as parameters.
module rrba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rrba_share.sv
// Two-stage constant divider: share = pool / SHARE_DIVISOR.
// Reciprocal multiply, then one compare-and-correct step. Uses rrba_pkg widths.
module rrba_share import rrba_pkg::*; #(
  parameter int SHARE_DIVISOR = SHARE_DIVISOR_DEF
) (
  input  logic               clk,
  input  logic [BLOCK_W-1:0] pool,
  output logic [BLOCK_W-1:0] share
);

  localparam int RECIP_SHIFT = BLOCK_W;
  localparam int RECIP_W     = BLOCK_W + 1;
  localparam int DIV_W       = 7;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << RECIP_SHIFT) / SHARE_DIVISOR);
  localparam logic [DIV_W-1:0]   DIVISOR = DIV_W'(SHARE_DIVISOR);

  logic [BLOCK_W+RECIP_W-1:0] approx_prod;
  logic [BLOCK_W-1:0]         quot_est;
  logic [BLOCK_W-1:0]         pool_d;
  logic [BLOCK_W+DIV_W-1:0]   back_prod;
  logic [BLOCK_W-1:0]         remainder;

  // Estimate: floor(pool * floor(2^16 / D) / 2^16) is the quotient or one less
  assign approx_prod = {{RECIP_W{1'b0}}, pool} * {{BLOCK_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    quot_est <= approx_prod[RECIP_SHIFT +: BLOCK_W];
    pool_d   <= pool;
  end

  // Correct the estimate with one compare against the divisor
  assign back_prod = {{DIV_W{1'b0}}, quot_est} * {{BLOCK_W{1'b0}}, DIVISOR};
  assign remainder = pool_d - back_prod[BLOCK_W-1:0];

  always_ff @(posedge clk) begin
    share <= (remainder >= BLOCK_W'(DIVISOR)) ? quot_est + 1'b1 : quot_est;
  end

endmodule

### design/round_robin_block_allocator_top.sv
// Top level of the round-robin block allocator: request queue control and pool.
// Depends on rrba_pkg, rrba_ram (queue storage) and rrba_share (pool divider).
//
//  channel   handshake             payload
//  request   start / busy          kind, client_id, request_blocks
//  result    done (strobe)         status, granted_client, granted_blocks,
//                                  blocks_left, pool_after
//  config    cfg_write             cfg_data (refill budget)
//
// Enqueue, refill, empty-queue and exhausted-pool requests complete from idle:
// the result strobes in the cycle after the request, and busy stays low.
// A serve that grants goes from idle through S_DIV to S_APPLY, with busy high in
// both: the queue memory read of the head entry and the first divider stage, then
// the divider correction, then the grant is applied and written back.
// Synchronous reset clears the queue pointers and sets pool and budget to 1000;
// the queue memory needs no clearing. The result cannot be stalled.
module round_robin_block_allocator_top import rrba_pkg::*; #(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int SHARE_DIVISOR = SHARE_DIVISOR_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [ID_W-1:0]    client_id,
  input  logic [BLOCK_W-1:0] request_blocks,
  input  logic               cfg_write,
  input  logic [BLOCK_W-1:0] cfg_data,
  output logic               done,
  output logic [STAT_W-1:0]  status,
  output logic [ID_W-1:0]    granted_client,
  output logic [BLOCK_W-1:0] granted_blocks,
  output logic [BLOCK_W-1:0] blocks_left,
  output logic [BLOCK_W-1:0] pool_after
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]         state;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [CNT_W-1:0]   count;
  logic [BLOCK_W-1:0] pool;
  logic [BLOCK_W-1:0] budget;

  logic               accept;
  logic               ram_we;
  rrba_entry_t        ram_wdata;
  rrba_entry_t        head_entry;
  logic [BLOCK_W-1:0] share;
  logic [BLOCK_W-1:0] grant;
  logic [BLOCK_W-1:0] left;
  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   tail_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign head_next = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_next = (tail == LAST_SLOT) ? '0 : tail + 1'b1;

  // Queue storage, read continuously at the head
  rrba_ram #(
    .WIDTH ($bits(rrba_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (head_entry)
  );

  // Pool share divider, fed from the pool register
  rrba_share #(
    .SHARE_DIVISOR (SHARE_DIVISOR)
  ) u_share (
    .clk   (clk),
    .pool  (pool),
    .share (share)
  );

  // Grant for the head entry
  assign grant = (head_entry.count < share) ? head_entry.count : share;
  assign left  = head_entry.count - grant;

  // Queue writes: enqueue requests at accept while not full, pushed-back entries after a grant
  always_comb begin
    ram_we          = 1'b0;
    ram_wdata.id    = client_id;
    ram_wdata.count = request_blocks;
    if (accept && (kind == KIND_ENQUEUE) && (count != FULL_COUNT)) begin
      ram_we = 1'b1;
    end
    if ((state == S_APPLY) && (left != '0)) begin
      ram_we          = 1'b1;
      ram_wdata.id    = head_entry.id;
      ram_wdata.count = left;
    end
  end

  // Control: pointers, fill count, pool, budget and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      pool   <= BUDGET_RESET;
      budget <= BUDGET_RESET;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        budget <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            case (kind)
              KIND_ENQUEUE: begin
                done <= 1'b1;
                if (count != FULL_COUNT) begin
                  tail  <= tail_next;
                  count <= count + 1'b1;
                end
              end
              KIND_REFILL: begin
                done <= 1'b1;
                pool <= budget;
              end
              KIND_SERVE: begin
                if ((count == '0) || (pool == '0)) begin
                  done <= 1'b1;
                end else begin
                  state <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          done <= 1'b1;
          head <= head_next;
          pool <= pool - grant;
          if (left != '0) begin
            tail <= tail_next;
          end else begin
            count <= count - 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      status         <= STAT_GRANTED;
      granted_client <= head_entry.id;
      granted_blocks <= grant;
      blocks_left    <= left;
      pool_after     <= pool - grant;
    end else if (accept) begin
      granted_client <= '0;
      granted_blocks <= '0;
      blocks_left    <= '0;
      pool_after     <= pool;
      case (kind)
        KIND_ENQUEUE: begin
          status <= (count == FULL_COUNT) ? STAT_FULL : STAT_ENQUEUED;
        end
        KIND_REFILL: begin
          status     <= STAT_REFILLED;
          pool_after <= budget;
        end
        KIND_SERVE: begin
          status <= (count == '0) ? STAT_EMPTY : STAT_EXHAUSTED;
        end
        default: status <= STAT_EMPTY;
      endcase
    end
  end

  // Fill count never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue fill count above depth");

  // Apply step always follows the divider wait step
  a_apply_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $past(state == S_DIV))
    else $error("apply step without divider wait");

  // A grant is only applied while the queue holds an entry and the pool is not empty
  a_apply_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> ((count != '0) && (pool != '0)))
    else $error("grant applied to empty queue or pool");

  // A granted result comes straight out of the apply step
  a_grant_source: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_GRANTED)) |-> $past(state == S_APPLY))
    else $error("granted result without apply step");

endmodule
